### design/quaternion_to_euler_angles_macros.svh
// Assertion macros used by the port-level checker of the quaternion to Euler angles block.
// No dependencies.
`ifndef QUATERNION_TO_EULER_ANGLES_MACROS_SVH
`define QUATERNION_TO_EULER_ANGLES_MACROS_SVH

// antecedent and consequent in the same cycle
`define QTE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qte: same-cycle check failed");

// consequent in the cycle after the antecedent
`define QTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qte: next-cycle check failed");

// next-cycle check that also runs while reset is asserted
`define QTE_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("qte: reset check failed");

`endif

### design/qte_pkg.sv
// Shared constants, types and the CORDIC step table for the quaternion to Euler block.
// No dependencies.
package qte_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int ANGLE_BITS_DEF     = 16;

    localparam int IN_W         = 16;  // quaternion component width
    localparam int MAG_W        = 62;  // atan2 operand magnitude width
    localparam int M_W          = 31;  // pitch sine magnitude, Q30 up to 1.0
    localparam int RAD_W        = 61;  // 2^60 - m^2
    localparam int RES_W        = 62;  // square root working register
    localparam int SQRT_STEPS   = 31;
    localparam int NORM_W       = 30;  // normalized operands lie below 2^30
    localparam int SH_W         = 6;   // bit index into MAG_W
    localparam int XY_W         = 34;  // CORDIC x/y, covers gain growth
    localparam int PHI_W        = 32;  // full turn = 2^32
    localparam int CORDIC_STEPS = 30;

    localparam int NUM_LANES  = 3;
    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    localparam logic [PHI_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [PHI_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // atan2(b, a) operands as magnitudes plus signs
    typedef struct packed {
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        logic             aneg;
        logic             bneg;
    } pair_t;

    // normalized operands with the flags the quadrant fix needs
    typedef struct packed {
        logic [NORM_W-1:0] a;
        logic [NORM_W-1:0] b;
        logic              aneg;
        logic              bneg;
        logic              az;
        logic              bz;
    } lane_t;

    // atan(2^-i), full turn = 2^32
    function automatic logic [PHI_W-1:0] step_angle(input int i);
        logic [PHI_W-1:0] r;
        case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [63:0] v);
        logic [63:0] u;
        u = v[63] ? 64'(-v) : 64'(v);
        return u[MAG_W-1:0];
    endfunction

endpackage

### design/qte_front.sv
// Front end: quaternion products, the five trig arguments, pitch clamp and magnitudes.
// Depends on qte_pkg. Three register stages.
module qte_front import qte_pkg::*; #(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [IN_W-1:0] quat_w,
    input  logic signed [IN_W-1:0] quat_x,
    input  logic signed [IN_W-1:0] quat_y,
    input  logic signed [IN_W-1:0] quat_z,
    output logic                   out_valid,
    output pair_t                  roll_pair,
    output pair_t                  yaw_pair,
    output logic [M_W-1:0]         pitch_mag,
    output logic                   pitch_neg
);

    localparam logic signed [63:0] ONE = 64'sd1 <<< (2 * QUAT_FRAC_BITS);
    localparam int RSH = (2 * QUAT_FRAC_BITS >= 30) ? 2 * QUAT_FRAC_BITS - 30 : 0;
    localparam int LSH = (2 * QUAT_FRAC_BITS < 30) ? 30 - 2 * QUAT_FRAC_BITS : 0;

    logic [2:0] valid_reg;

    logic signed [2*IN_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg;
    logic signed [2*IN_W-1:0] wz_reg, xy_reg, zz_reg;
    logic signed [63:0] t0_reg, t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [63:0] t0_next, t1_next, t2_next, t3_next, t4_next;
    logic signed [63:0] t2c;
    logic [63:0]        m64;
    pair_t              roll_reg, yaw_reg, roll_next, yaw_next;
    logic [M_W-1:0]     mag_reg, mag_next;
    logic               neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_comb
    begin
        t0_next = (64'(wx_reg) + 64'(yz_reg)) <<< 1;
        t1_next = ONE - ((64'(xx_reg) + 64'(yy_reg)) <<< 1);
        t2_next = (64'(wy_reg) - 64'(zx_reg)) <<< 1;
        t3_next = (64'(wz_reg) + 64'(xy_reg)) <<< 1;
        t4_next = ONE - ((64'(yy_reg) + 64'(zz_reg)) <<< 1);
    end

    always_comb
    begin
        if (t2_reg > ONE)
        begin
            t2c = ONE;
        end
        else if (t2_reg < -ONE)
        begin
            t2c = -ONE;
        end
        else
        begin
            t2c = t2_reg;
        end
        m64      = t2c[63] ? 64'(-t2c) : 64'(t2c);
        mag_next = M_W'((m64 >> RSH) << LSH);
        roll_next = '{a: mag_of(t1_reg), b: mag_of(t0_reg),
                      aneg: t1_reg[63], bneg: t0_reg[63]};
        yaw_next  = '{a: mag_of(t4_reg), b: mag_of(t3_reg),
                      aneg: t4_reg[63], bneg: t3_reg[63]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg   <= quat_w * quat_x;
            yz_reg   <= quat_y * quat_z;
            xx_reg   <= quat_x * quat_x;
            yy_reg   <= quat_y * quat_y;
            wy_reg   <= quat_w * quat_y;
            zx_reg   <= quat_z * quat_x;
            wz_reg   <= quat_w * quat_z;
            xy_reg   <= quat_x * quat_y;
            zz_reg   <= quat_z * quat_z;
            t0_reg   <= t0_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            t3_reg   <= t3_next;
            t4_reg   <= t4_next;
            roll_reg <= roll_next;
            yaw_reg  <= yaw_next;
            mag_reg  <= mag_next;
            neg_reg  <= t2c[63];
        end
    end

    assign out_valid = valid_reg[2];
    assign roll_pair = roll_reg;
    assign yaw_pair  = yaw_reg;
    assign pitch_mag = mag_reg;
    assign pitch_neg = neg_reg;

endmodule

### design/qte_pitch.sv
// Pitch cosine: m^2 from split partial products, then a one-bit-per-stage square root
// of 2^60 - m^2. Roll and yaw operands ride alongside. Depends on qte_pkg.
module qte_pitch import qte_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  pair_t                 roll_pair,
    input  pair_t                 yaw_pair,
    input  logic [M_W-1:0]        pitch_mag,
    input  logic                  pitch_neg,
    output logic                  out_valid,
    output pair_t [NUM_LANES-1:0] lanes
);

    localparam int PIPE = 2 + SQRT_STEPS;

    typedef struct packed {
        pair_t          roll;
        pair_t          yaw;
        logic [M_W-1:0] mag;
        logic           neg;
    } side_t;

    logic [PIPE-1:0] valid_reg;
    side_t           side_reg [PIPE];

    logic [14:0]     mh;
    logic [15:0]     ml;
    logic [29:0]     hh_reg;
    logic [30:0]     hl_reg;
    logic [31:0]     ll_reg;
    logic [RES_W-1:0] msq;
    logic [RES_W-1:0] rad_full;
    logic [RAD_W-1:0] rad_reg;

    logic [RAD_W-1:0] n_reg   [SQRT_STEPS];
    logic [RES_W-1:0] res_reg [SQRT_STEPS];

    assign mh = pitch_mag[30:16];
    assign ml = pitch_mag[15:0];

    always_comb
    begin
        msq      = (RES_W'(hh_reg) << 32) + (RES_W'(hl_reg) << 17) + RES_W'(ll_reg);
        rad_full = (RES_W'(1) << 60) - msq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg      <= mh * mh;
            hl_reg      <= mh * ml;
            ll_reg      <= ml * ml;
            rad_reg     <= rad_full[RAD_W-1:0];
            side_reg[0] <= '{roll: roll_pair, yaw: yaw_pair, mag: pitch_mag, neg: pitch_neg};
            for (int k = 1; k < PIPE; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // restoring square root, test bit 2^(60-2k) at stage k
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [RES_W-1:0] BIT = RES_W'(1) << (RAD_W - 1 - 2 * k);
        logic [RAD_W-1:0] n_in, n_next;
        logic [RES_W-1:0] res_in, res_next, trial;

        if (k == 0)
        begin : g_first
            assign n_in   = rad_reg;
            assign res_in = '0;
        end
        else
        begin : g_rest
            assign n_in   = n_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (RES_W'(n_in) >= trial)
            begin
                n_next   = n_in - trial[RAD_W-1:0];
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                n_next   = n_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]   <= n_next;
                res_reg[k] <= res_next;
            end
        end
    end

    always_comb
    begin
        lanes[LANE_ROLL]  = side_reg[PIPE-1].roll;
        lanes[LANE_YAW]   = side_reg[PIPE-1].yaw;
        lanes[LANE_PITCH] = '{a: MAG_W'(res_reg[SQRT_STEPS-1][M_W-1:0]),
                              b: MAG_W'(side_reg[PIPE-1].mag),
                              aneg: 1'b0, bneg: side_reg[PIPE-1].neg};
    end

    assign out_valid = valid_reg[PIPE-1];

endmodule

### design/qte_norm.sv
// Operand normalizer: leading-one search, then a shared shift that brings the larger
// operand into [2^29, 2^30). Two register stages, three lanes. Depends on qte_pkg.
module qte_norm import qte_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  pair_t [NUM_LANES-1:0] lanes_in,
    output logic                  out_valid,
    output lane_t [NUM_LANES-1:0] lanes_out
);

    typedef struct packed {
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
        logic [SH_W-1:0]  msb;
        logic             aneg;
        logic             bneg;
        logic             az;
        logic             bz;
    } find_t;

    logic [1:0] valid_reg;
    find_t      find_reg [NUM_LANES];
    lane_t      out_reg  [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], in_valid};
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        logic [MAG_W-1:0] either;
        logic [SH_W-1:0]  msb_next;
        logic [MAG_W-1:0] sa, sb;

        always_comb
        begin
            either   = lanes_in[l].a | lanes_in[l].b;
            msb_next = '0;
            for (int j = 0; j < MAG_W; j++)
            begin
                if (either[j])
                begin
                    msb_next = SH_W'(j);
                end
            end
        end

        always_comb
        begin
            if (find_reg[l].msb >= SH_W'(NORM_W - 1))
            begin
                sa = find_reg[l].a >> (find_reg[l].msb - SH_W'(NORM_W - 1));
                sb = find_reg[l].b >> (find_reg[l].msb - SH_W'(NORM_W - 1));
            end
            else
            begin
                sa = find_reg[l].a << (SH_W'(NORM_W - 1) - find_reg[l].msb);
                sb = find_reg[l].b << (SH_W'(NORM_W - 1) - find_reg[l].msb);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                find_reg[l] <= '{a: lanes_in[l].a, b: lanes_in[l].b, msb: msb_next,
                                 aneg: lanes_in[l].aneg, bneg: lanes_in[l].bneg,
                                 az: (lanes_in[l].a == '0), bz: (lanes_in[l].b == '0)};
                out_reg[l]  <= '{a: sa[NORM_W-1:0], b: sb[NORM_W-1:0],
                                 aneg: find_reg[l].aneg, bneg: find_reg[l].bneg,
                                 az: find_reg[l].az, bz: find_reg[l].bz};
            end
        end

        assign lanes_out[l] = out_reg[l];
    end

    assign out_valid = valid_reg[1];

endmodule

### design/qte_cordic.sv
// Vectoring CORDIC, one iteration per stage on three lanes, then quadrant fix and
// rounding to the output angle width in a final output register. Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  lane_t [NUM_LANES-1:0]        lanes,
    output logic                         out_valid,
    output logic signed [ANGLE_BITS-1:0] roll_angle,
    output logic signed [ANGLE_BITS-1:0] pitch_angle,
    output logic signed [ANGLE_BITS-1:0] yaw_angle
);

    localparam int SH = PHI_W - ANGLE_BITS;
    localparam logic [PHI_W:0] RND = ((PHI_W + 1)'(1) << SH) >> 1;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [PHI_W-1:0]       z;
        logic                   aneg;
        logic                   bneg;
        logic                   az;
        logic                   bz;
    } cst_t;

    logic [CORDIC_STEPS:0]  valid_reg;
    cst_t                   st_reg  [CORDIC_STEPS][NUM_LANES];
    logic [ANGLE_BITS-1:0]  ang_reg [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[CORDIC_STEPS-1:0], in_valid};
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_lane
        for (genvar i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            cst_t cur, nxt;

            if (i == 0)
            begin : g_first
                assign cur = '{x: signed'(XY_W'(lanes[l].a)), y: signed'(XY_W'(lanes[l].b)),
                               z: '0, aneg: lanes[l].aneg, bneg: lanes[l].bneg,
                               az: lanes[l].az, bz: lanes[l].bz};
            end
            else
            begin : g_rest
                assign cur = st_reg[i-1][l];
            end

            always_comb
            begin
                nxt = cur;
                if (!cur.y[XY_W-1])
                begin
                    nxt.x = cur.x + (cur.y >>> i);
                    nxt.y = cur.y - (cur.x >>> i);
                    nxt.z = cur.z + step_angle(i);
                end
                else
                begin
                    nxt.x = cur.x - (cur.y >>> i);
                    nxt.y = cur.y + (cur.x >>> i);
                    nxt.z = cur.z - step_angle(i);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[i][l] <= nxt;
                end
            end
        end

        // special operands override the rotation result, then mirror into the quadrant
        cst_t             fin;
        logic [PHI_W-1:0] phi;
        logic [PHI_W:0]   rounded;

        assign fin = st_reg[CORDIC_STEPS-1][l];

        always_comb
        begin
            if (fin.bz)
            begin
                phi = '0;
            end
            else if (fin.az)
            begin
                phi = QUARTER_TURN;
            end
            else
            begin
                phi = fin.z;
            end
            if (fin.aneg)
            begin
                phi = HALF_TURN - phi;
            end
            if (fin.bneg)
            begin
                phi = -phi;
            end
            rounded = {1'b0, phi} + RND;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ang_reg[l] <= rounded[PHI_W-1:SH];
            end
        end
    end

    assign out_valid   = valid_reg[CORDIC_STEPS];
    assign roll_angle  = signed'(ang_reg[LANE_ROLL]);
    assign pitch_angle = signed'(ang_reg[LANE_PITCH]);
    assign yaw_angle   = signed'(ang_reg[LANE_YAW]);

endmodule

### design/quaternion_to_euler_angles.sv
// Quaternion to ZYX Euler angles (roll, pitch, yaw), fully pipelined.
// Register stages: 3 front end, 33 pitch and square root, 2 normalize, 31 CORDIC and output.
// Throughput: one transfer per cycle unless the output stalls; the pitch square root and
// the three CORDIC lanes each have one stage per iteration. A stalled output freezes the
// whole pipeline. Reset (rst_n low, asynchronous) clears the valid bits only.
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [4*IN_W-1:0]                 s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [((3*ANGLE_BITS+7)/8)*8-1:0] m_tdata   // roll_angle, pitch_angle, yaw_angle
);

    localparam int OUT_W = ((3 * ANGLE_BITS + 7) / 8) * 8;

    logic                  en;
    logic                  front_valid, pitch_valid, norm_valid;
    pair_t                 roll_pair, yaw_pair;
    logic [M_W-1:0]        pitch_mag;
    logic                  pitch_neg;
    pair_t [NUM_LANES-1:0] pairs;
    lane_t [NUM_LANES-1:0] lanes;

    logic signed [ANGLE_BITS-1:0] roll_angle, pitch_angle, yaw_angle;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    qte_front #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .quat_w    (signed'(s_tdata[IN_W-1:0])),
        .quat_x    (signed'(s_tdata[2*IN_W-1:IN_W])),
        .quat_y    (signed'(s_tdata[3*IN_W-1:2*IN_W])),
        .quat_z    (signed'(s_tdata[4*IN_W-1:3*IN_W])),
        .out_valid (front_valid),
        .roll_pair (roll_pair),
        .yaw_pair  (yaw_pair),
        .pitch_mag (pitch_mag),
        .pitch_neg (pitch_neg)
    );

    qte_pitch u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .roll_pair (roll_pair),
        .yaw_pair  (yaw_pair),
        .pitch_mag (pitch_mag),
        .pitch_neg (pitch_neg),
        .out_valid (pitch_valid),
        .lanes     (pairs)
    );

    qte_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pitch_valid),
        .lanes_in  (pairs),
        .out_valid (norm_valid),
        .lanes_out (lanes)
    );

    qte_cordic #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (norm_valid),
        .lanes       (lanes),
        .out_valid   (m_tvalid),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle)
    );

    assign m_tdata = OUT_W'({yaw_angle, pitch_angle, roll_angle});

endmodule

### design/qte_port_chk.sv
// Port-level checker for quaternion_to_euler_angles, bound to the top level.
// Depends on qte_pkg and quaternion_to_euler_angles_macros.svh.
`include "quaternion_to_euler_angles_macros.svh"

module qte_port_chk import qte_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [4*IN_W-1:0]                 s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((3*ANGLE_BITS+7)/8)*8-1:0] m_tdata
);

    // a waiting result holds
    `QTE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // the input side moves exactly when the output register can move
    `QTE_ASSERT_SAME(a_ready_link, clk, rst_n, s_tvalid || !s_tvalid, s_tready == (!m_tvalid || m_tready))

    // nothing leaves in the cycle after reset
    `QTE_ASSERT_NEXT_NR(a_reset_quiet, clk, !rst_n, !m_tvalid)

endmodule

bind quaternion_to_euler_angles qte_port_chk #(.ANGLE_BITS(ANGLE_BITS)) u_port_chk (.*);
